FILE: design/aes_pkg.sv
// Shared constants, types and the S-box table for the AES block encryptor.
package aes_pkg;

  // Number of cipher rounds (10 for AES-128; 12 and 14 also supported).
  localparam int ROUNDS = 10;
  // One 128-bit round key per round plus the initial key.
  localparam int KEY_DEPTH = ROUNDS + 1;
  localparam int KEY_AW = $clog2(KEY_DEPTH);
  localparam int BLK_W = 128;
  localparam int HALF_W = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the plaintext into the state register
    logic first;    // initial key addition
    logic mid;      // full round
    logic last;     // final round into the result register
  } cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

endpackage

FILE: design/aes_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/aes_ctrl.sv
// Controller: accepts items, sequences the rounds and owns the result valid flag.
module aes_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_op,
  input  logic [3:0]                in_round_index,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output aes_pkg::cmd_t             cmd,
  output logic                      key_we,
  output logic [aes_pkg::KEY_AW-1:0] key_rd_addr
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic OP_LOAD = 1'b0;

  logic                       state_r, state_nxt;
  logic [aes_pkg::KEY_AW-1:0] rnd_r, rnd_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequence one encrypt item: the key for the next round is read in the cycle before its round
  always_comb begin
    state_nxt   = state_r;
    rnd_nxt     = rnd_r;
    cmd         = '0;
    key_we      = 1'b0;
    key_rd_addr = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            // drop loads beyond the schedule
            key_we = (in_round_index <= 4'(aes_pkg::ROUNDS));
          end else begin
            cmd.capture = 1'b1;
            rnd_nxt     = '0;
            state_nxt   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (rnd_r != aes_pkg::KEY_AW'(aes_pkg::ROUNDS)) begin
          cmd.first   = (rnd_r == '0);
          cmd.mid     = (rnd_r != '0);
          rnd_nxt     = aes_pkg::KEY_AW'(rnd_r + 1'b1);
          key_rd_addr = aes_pkg::KEY_AW'(rnd_r + 1'b1);
        end else if (out_free) begin
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          // hold the final round until the result register frees up
          key_rd_addr = rnd_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid: set by the final round, cleared when the item is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/aes_dp.sv
// Datapath: block state register, shared round unit and result register.
module aes_dp (
  input  logic                       clk,
  input  aes_pkg::cmd_t              cmd,
  input  logic [aes_pkg::HALF_W-1:0] in_data_hi,
  input  logic [aes_pkg::HALF_W-1:0] in_data_lo,
  input  logic [aes_pkg::BLK_W-1:0]  round_key,
  output logic [aes_pkg::HALF_W-1:0] out_cipher_hi,
  output logic [aes_pkg::HALF_W-1:0] out_cipher_lo
);

  logic [aes_pkg::BLK_W-1:0] blk_r, blk_nxt;
  logic [aes_pkg::BLK_W-1:0] cipher_r;
  logic [aes_pkg::BLK_W-1:0] sub_shift;
  logic [aes_pkg::BLK_W-1:0] mixed;

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    logic [7:0] r;
    r = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    return r;
  endfunction

  // SubBytes and ShiftRows; byte i sits at the top of the block for i = 0
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sub_shift[127 - 8 * i -: 8] =
        aes_pkg::SBOX[blk_r[127 - 8 * ((i + 4 * (i & 3)) & 15) -: 8]];
    end
  end

  // MixColumns over the four columns
  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] d0, d1, d2, d3;
    for (int c = 0; c < 4; c++) begin
      a0 = sub_shift[127 - 32 * c -: 8];
      a1 = sub_shift[119 - 32 * c -: 8];
      a2 = sub_shift[111 - 32 * c -: 8];
      a3 = sub_shift[103 - 32 * c -: 8];
      d0 = xtime(a0);
      d1 = xtime(a1);
      d2 = xtime(a2);
      d3 = xtime(a3);
      mixed[127 - 32 * c -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
      mixed[119 - 32 * c -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
      mixed[111 - 32 * c -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
      mixed[103 - 32 * c -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end
  end

  // Select the next block state
  always_comb begin
    blk_nxt = blk_r;
    if (cmd.capture) begin
      blk_nxt = {in_data_hi, in_data_lo};
    end else if (cmd.first) begin
      blk_nxt = blk_r ^ round_key;
    end else if (cmd.mid) begin
      blk_nxt = mixed ^ round_key;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (cmd.last) begin
      cipher_r <= sub_shift ^ round_key;
    end
  end

  assign out_cipher_hi = cipher_r[127:64];
  assign out_cipher_lo = cipher_r[63:0];

endmodule

FILE: design/aes_block_encrypt.sv
// Top level of the AES block encryptor: controller, datapath and round key RAM.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in_     | input     | in_valid / in_ready  | in_op, in_round_index, in_data_hi/lo
//  out_    | output    | out_valid / out_ready| out_cipher_hi, out_cipher_lo
//
//  A key load leaves the block idle. An encrypt item runs the initial key addition
//  and then ROUNDS rounds through the one shared round unit, paced by the one
//  read port of the round key RAM; the next item is taken the cycle after the
//  final round. The result waits in a register; the final round holds while
//  that register is still occupied. Reset clears control only; the key RAM
//  is undefined until loaded.
module aes_block_encrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [3:0]  in_round_index,
  input  logic [63:0] in_data_hi,
  input  logic [63:0] in_data_lo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_hi,
  output logic [63:0] out_cipher_lo
);

  aes_pkg::cmd_t              cmd;
  logic                       key_we;
  logic [aes_pkg::KEY_AW-1:0] key_rd_addr;
  logic [aes_pkg::BLK_W-1:0]  round_key;

  aes_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_op          (in_op),
    .in_round_index (in_round_index),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .key_we         (key_we),
    .key_rd_addr    (key_rd_addr)
  );

  aes_ram #(
    .WIDTH (aes_pkg::BLK_W),
    .DEPTH (aes_pkg::KEY_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (in_round_index[aes_pkg::KEY_AW-1:0]),
    .wr_data ({in_data_hi, in_data_lo}),
    .rd_addr (key_rd_addr),
    .rd_data (round_key)
  );

  aes_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .in_data_hi    (in_data_hi),
    .in_data_lo    (in_data_lo),
    .round_key     (round_key),
    .out_cipher_hi (out_cipher_hi),
    .out_cipher_lo (out_cipher_lo)
  );

endmodule

FILE: design/aes_chk.sv
// Port-level checker for the AES block encryptor, bound to the top level.
module aes_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_cipher_hi,
  input logic [63:0] out_cipher_lo
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cipher_hi) && $stable(out_cipher_lo))
    else $error("stalled result changed");

  // An accepted encrypt item keeps the block busy the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op |=> !in_ready)
    else $error("encrypt item did not occupy the block");

  // A key load never makes the block busy
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_op |=> in_ready)
    else $error("key load made the block busy");

  // A result appears only at the end of a busy period
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // Reset leaves no result pending
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind aes_block_encrypt aes_chk u_aes_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_cipher_hi (out_cipher_hi),
  .out_cipher_lo (out_cipher_lo)
);
